/* rtl/core/tdc_wup_pkg.sv */
package tdc_wup_pkg;

  // edge queue geometry
  localparam int unsigned FifoDepth = 16;
  localparam int unsigned FifoIdxW  = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  // configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  // special tdc ids
  localparam logic [15:0] RefTdc = 16'h0110;
  localparam logic [15:0] CtsTdc = 16'h7005;

  // reference tdc channels
  localparam logic [6:0] ChanFinger = 7'd1;
  localparam logic [6:0] ChanBeam   = 7'd5;
  localparam logic [6:0] ChanLaser  = 7'd7;
  localparam logic [6:0] ChanLed    = 7'd15;

  // word tag of an epoch word in bits 31..29
  localparam logic [2:0] TagEpoch = 3'b011;

  // configuration reset values
  localparam logic [63:0] LeadMaskRst = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam logic [63:0] SyncLoRst   = 64'h1;

  typedef enum logic [1:0] {
    HIT_PAIR   = 2'd0,
    HIT_TRIG   = 2'd1,
    HIT_FINGER = 2'd2
  } hit_kind_e;

  typedef enum logic [1:0] {
    MODE_BEAM  = 2'd0,
    MODE_LASER = 2'd1,
    MODE_LED   = 2'd2
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LEAD_LO = 3'd0,
    CFG_LEAD_HI = 3'd1,
    CFG_SYNC_LO = 3'd2,
    CFG_SYNC_HI = 3'd3,
    CFG_MODE    = 3'd4,
    CFG_FINGER  = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [6:0]  channel;
    logic [27:0] epoch;
    logic [10:0] coarse;
    logic [9:0]  fine;
  } edge_t;

  localparam int unsigned EdgeW = $bits(edge_t);

  typedef struct packed {
    logic [127:0] lead_mask;
    logic [127:0] sync_mask;
    logic [1:0]   mode;
    logic         finger;
  } cfg_t;

  typedef struct packed {
    hit_kind_e   hit_kind;
    logic [15:0] hit_tdc;
    edge_t       lead;
    edge_t       trail;
    logic [31:0] unpaired_count;
  } result_t;

endpackage

/* rtl/core/tdc_wup_if.sv */
interface tdc_wup_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] word;
  logic [15:0] tdc_id;
  logic        pmt_board;
  logic        block_start;

  modport source (output valid, word, tdc_id, pmt_board, block_start, input ready);
  modport sink   (input valid, word, tdc_id, pmt_board, block_start, output ready);
endinterface

interface tdc_wup_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  hit_kind;
  logic [15:0] hit_tdc;
  logic [6:0]  lead_channel;
  logic [27:0] lead_epoch;
  logic [10:0] lead_coarse;
  logic [9:0]  lead_fine;
  logic [6:0]  trail_channel;
  logic [27:0] trail_epoch;
  logic [10:0] trail_coarse;
  logic [9:0]  trail_fine;
  logic [31:0] unpaired_count;

  modport source (output valid, hit_kind, hit_tdc, lead_channel, lead_epoch, lead_coarse,
                  lead_fine, trail_channel, trail_epoch, trail_coarse, trail_fine,
                  unpaired_count, input ready);
  modport sink   (input valid, hit_kind, hit_tdc, lead_channel, lead_epoch, lead_coarse,
                  lead_fine, trail_channel, trail_epoch, trail_coarse, trail_fine,
                  unpaired_count, output ready);
endinterface

/* rtl/core/tdc_wup_ram.sv */
module tdc_wup_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr0_i,
  input  logic [AddrW-1:0] raddr1_i,
  output logic [Width-1:0] rdata0_o,
  output logic [Width-1:0] rdata1_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata0_q;
  logic [Width-1:0] rdata1_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // two registered read ports
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata0_q <= mem_q[raddr0_i];
      rdata1_q <= mem_q[raddr1_i];
    end
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

/* rtl/core/tdc_wup_cfg.sv */
module tdc_wup_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         we_i,
  input  logic [tdc_wup_pkg::CfgIdxW-1:0]  idx_i,
  input  logic [tdc_wup_pkg::CfgDataW-1:0] data_i,
  output tdc_wup_pkg::cfg_t            cfg_o
);
  import tdc_wup_pkg::*;

  logic [63:0] lead_lo_q, lead_hi_q, sync_lo_q, sync_hi_q;
  logic [1:0]  mode_q;
  logic        finger_q;

  // register file, written by index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_lo_q <= LeadMaskRst;
      lead_hi_q <= LeadMaskRst;
      sync_lo_q <= SyncLoRst;
      sync_hi_q <= '0;
      mode_q    <= MODE_BEAM;
      finger_q  <= 1'b0;
    end else if (we_i) begin
      unique case (cfg_reg_e'(idx_i))
        CFG_LEAD_LO: lead_lo_q <= data_i;
        CFG_LEAD_HI: lead_hi_q <= data_i;
        CFG_SYNC_LO: sync_lo_q <= data_i;
        CFG_SYNC_HI: sync_hi_q <= data_i;
        CFG_MODE:    mode_q    <= data_i[1:0];
        CFG_FINGER:  finger_q  <= data_i[0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_o.lead_mask = {lead_hi_q, lead_lo_q};
  assign cfg_o.sync_mask = {sync_hi_q, sync_lo_q};
  assign cfg_o.mode      = mode_q;
  assign cfg_o.finger    = finger_q;

endmodule

/* rtl/core/tdc_wup_obuf.sv */
module tdc_wup_obuf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  tdc_wup_pkg::result_t data_i,
  output logic                 space_o,
  tdc_wup_out_if.source        out_o
);
  import tdc_wup_pkg::*;

  result_t    slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;
  result_t    head;

  assign pop     = out_o.valid && out_o.ready;
  assign space_o = (cnt_q != 2'd2);
  assign cnt_d   = cnt_q + {1'b0, push_i} - {1'b0, pop};

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop)    rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_d;
    end
  end

  // result slots
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  assign head = slot_q[rd_ptr_q];

  assign out_o.valid          = (cnt_q != 2'd0);
  assign out_o.hit_kind       = head.hit_kind;
  assign out_o.hit_tdc        = head.hit_tdc;
  assign out_o.lead_channel   = head.lead.channel;
  assign out_o.lead_epoch     = head.lead.epoch;
  assign out_o.lead_coarse    = head.lead.coarse;
  assign out_o.lead_fine      = head.lead.fine;
  assign out_o.trail_channel  = head.trail.channel;
  assign out_o.trail_epoch    = head.trail.epoch;
  assign out_o.trail_coarse   = head.trail.coarse;
  assign out_o.trail_fine     = head.trail.fine;
  assign out_o.unpaired_count = head.unpaired_count;

endmodule

/* rtl/core/tdc_word_unpack_edge_pairing.sv */
// accepted words wait in the pending stage; results are pushed into the result buffer
// throughput: one word per cycle; the edge memory is read in the accept cycle at the head
//   address left by the previous word's pairing compare; words follow back to back while
//   the result buffer has space; its two entries hold results while the output stalls
// reset: control state, epoch, queue pointers and unpaired count go to zero and the
//   registers to their defaults; the edge memory is not cleared
module tdc_word_unpack_edge_pairing (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  tdc_wup_in_if.sink                       in_i,
  tdc_wup_out_if.source                    out_o,
  input  logic                             cfg_we_i,
  input  logic [tdc_wup_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tdc_wup_pkg::CfgDataW-1:0] cfg_data_i
);
  import tdc_wup_pkg::*;

  localparam int unsigned SumW = FifoCntW + 1;
  localparam logic [SumW-1:0] DepthSum = SumW'(FifoDepth);
  localparam logic [FifoCntW-1:0] DepthCnt = FifoCntW'(FifoDepth);

  function automatic logic [FifoIdxW-1:0] idx_wrap(input logic [SumW-1:0] sum);
    logic [SumW-1:0] red;
    red = (sum >= DepthSum) ? sum - DepthSum : sum;
    return red[FifoIdxW-1:0];
  endfunction

  cfg_t cfg;

  tdc_wup_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  // handshake and pipeline control
  logic adv, accept, commit, ob_space;

  assign adv        = ob_space;
  assign in_i.ready = adv;
  assign accept     = in_i.valid && adv;

  // architectural state
  logic [27:0]         epoch_q;
  logic [FifoIdxW-1:0] head_q;
  logic [FifoCntW-1:0] cnt_q;
  logic [31:0]         unp_q;

  // item waiting for its memory data
  logic        pend_valid_q;
  logic [31:0] pend_word_q;
  logic [15:0] pend_tdc_q;
  logic        pend_pmt_q;
  logic        pend_bs_q;
  logic        fwd0_q, fwd1_q;
  edge_t       fwd_data_q;

  assign commit = adv && pend_valid_q;

  // memory ports
  logic                wr_en;
  logic [FifoIdxW-1:0] wr_addr;
  edge_t               wr_data;
  logic [FifoIdxW-1:0] ra0, ra1;
  logic [EdgeW-1:0]    rd0, rd1;

  tdc_wup_ram #(
    .Width (EdgeW),
    .Depth (FifoDepth)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (wr_en),
    .waddr_i  (wr_addr),
    .wdata_i  (wr_data),
    .re_i     (accept),
    .raddr0_i (ra0),
    .raddr1_i (ra1),
    .rdata0_o (rd0),
    .rdata1_o (rd1)
  );

  // decode of the pending word
  logic [27:0]         epoch_e;
  logic [FifoIdxW-1:0] head_e, head_p1, head_p2;
  logic [FifoCntW-1:0] cnt_e;
  logic [6:0]          ch;
  logic                is_time, is_epoch, ignored, is_ref, trig, lead_bit;
  edge_t               cur, e0, e1;
  logic                ok0, ok1;

  assign epoch_e  = pend_bs_q ? '0 : epoch_q;
  assign head_e   = pend_bs_q ? '0 : head_q;
  assign cnt_e    = pend_bs_q ? '0 : cnt_q;
  assign head_p1  = idx_wrap(SumW'(head_e) + SumW'(1));
  assign head_p2  = idx_wrap(SumW'(head_e) + SumW'(2));

  assign is_time  = pend_word_q[31];
  assign is_epoch = (pend_word_q[31:29] == TagEpoch);
  assign ch       = pend_word_q[28:22];

  assign cur.channel = ch;
  assign cur.epoch   = epoch_e;
  assign cur.coarse  = pend_word_q[10:0];
  assign cur.fine    = pend_word_q[21:12];

  assign ignored  = cfg.sync_mask[ch] || (pend_tdc_q == CtsTdc);
  assign is_ref   = (pend_tdc_q == RefTdc);
  assign lead_bit = cfg.lead_mask[ch];

  // trigger channel by analysis mode
  always_comb begin
    case (cfg.mode)
      MODE_BEAM:  trig = (ch == ChanBeam);
      MODE_LASER: trig = (ch == ChanLaser);
      MODE_LED:   trig = (ch == ChanLed);
      default:    trig = 1'b0;
    endcase
  end

  // queue entries, with bypass of a same-cycle write
  assign e0  = fwd0_q ? fwd_data_q : edge_t'(rd0);
  assign e1  = fwd1_q ? fwd_data_q : edge_t'(rd1);
  assign ok0 = ({1'b0, e0.channel} + 8'd1) == {1'b0, ch};
  assign ok1 = ({1'b0, e1.channel} + 8'd1) == {1'b0, ch};

  // pairing and state update
  logic                hit, push;
  hit_kind_e           kind;
  edge_t               lead, trail;
  logic [27:0]         epoch_n;
  logic [FifoIdxW-1:0] head_n;
  logic [FifoCntW-1:0] cnt_n;
  logic [1:0]          unp_inc;
  logic [32:0]         unp_sum;
  logic [31:0]         unp_n;

  always_comb begin
    hit     = 1'b0;
    push    = 1'b0;
    kind    = HIT_PAIR;
    lead    = '0;
    trail   = '0;
    epoch_n = epoch_e;
    head_n  = head_e;
    cnt_n   = cnt_e;
    unp_inc = 2'd0;
    if (is_time) begin
      if (!ignored) begin
        if (is_ref) begin
          if (trig) begin
            hit  = 1'b1;
            kind = HIT_TRIG;
            lead = cur;
          end else if (cfg.finger && (ch == ChanFinger)) begin
            hit  = 1'b1;
            kind = HIT_FINGER;
            lead = cur;
          end
        end else if (pend_pmt_q) begin
          if (lead_bit) begin
            if (cnt_e != DepthCnt) begin
              push  = 1'b1;
              cnt_n = cnt_e + FifoCntW'(1);
            end
          end else if (cnt_e == '0) begin
            unp_inc = 2'd1;
          end else if (ok0) begin
            hit    = 1'b1;
            lead   = e0;
            trail  = cur;
            head_n = head_p1;
            cnt_n  = cnt_e - FifoCntW'(1);
          end else if (cnt_e == FifoCntW'(1)) begin
            unp_inc = 2'd2;
            head_n  = head_p1;
            cnt_n   = '0;
          end else begin
            unp_inc = 2'd1;
            if (ok1) begin
              hit    = 1'b1;
              lead   = e1;
              trail  = cur;
              head_n = head_p2;
              cnt_n  = cnt_e - FifoCntW'(2);
            end else begin
              head_n = '0;
              cnt_n  = '0;
            end
          end
        end
      end
    end else if (is_epoch) begin
      epoch_n = pend_word_q[27:0];
    end
  end

  // saturating unpaired count
  assign unp_sum = {1'b0, unp_q} + {31'd0, unp_inc};
  assign unp_n   = unp_sum[32] ? '1 : unp_sum[31:0];

  // push of a leading edge at the tail
  assign wr_en   = commit && push;
  assign wr_addr = idx_wrap(SumW'(head_e) + SumW'(cnt_e));
  assign wr_data = cur;

  // read addresses follow the head left by the pending item
  logic [FifoIdxW-1:0] head_nx;

  assign head_nx = commit ? head_n : head_q;
  assign ra0     = head_nx;
  assign ra1     = idx_wrap(SumW'(head_nx) + SumW'(1));

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q <= '0;
      head_q  <= '0;
      cnt_q   <= '0;
      unp_q   <= '0;
    end else if (commit) begin
      epoch_q <= epoch_n;
      head_q  <= head_n;
      cnt_q   <= cnt_n;
      unp_q   <= unp_n;
    end
  end

  // pending stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      fwd0_q       <= 1'b0;
      fwd1_q       <= 1'b0;
    end else if (adv) begin
      pend_valid_q <= accept;
      fwd0_q       <= accept && wr_en && (wr_addr == ra0);
      fwd1_q       <= accept && wr_en && (wr_addr == ra1);
    end
  end

  // pending stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_word_q <= in_i.word;
      pend_tdc_q  <= in_i.tdc_id;
      pend_pmt_q  <= in_i.pmt_board;
      pend_bs_q   <= in_i.block_start;
      fwd_data_q  <= wr_data;
    end
  end

  // result assembly
  result_t res;

  assign res.hit_kind       = kind;
  assign res.hit_tdc        = pend_tdc_q;
  assign res.lead           = lead;
  assign res.trail          = trail;
  assign res.unpaired_count = unp_n;

  tdc_wup_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (commit && hit),
    .data_i  (res),
    .space_o (ob_space),
    .out_o   (out_o)
  );

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= DepthCnt)
    else $error("edge queue count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && pend_bs_q && !push |=> cnt_q == '0)
    else $error("block start did not empty the edge queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) 1'b1 |=> unp_q >= $past(unp_q))
    else $error("unpaired count went down");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !commit |=> $stable(head_q) && $stable(cnt_q))
    else $error("queue pointers moved without an item");
`endif

endmodule

/* tb/tb_tdc_word_unpack_edge_pairing.sv */
module tb_tdc_word_unpack_edge_pairing;
  timeunit 1ns;
  timeprecision 1ps;

  import tdc_wup_pkg::*;

  localparam int unsigned Limit = 500_000;
  localparam int unsigned SettleCycles = 8;

  // predicts hits from accepted words and checks them in arrival order
  class hit_predictor;
    logic [127:0] lead_mask;
    logic [127:0] sync_mask;
    logic [1:0]   mode;
    logic         finger;
    logic [27:0]  epoch;
    logic [31:0]  unpaired;
    edge_t        edge_queue[$];
    result_t      hits_due[$];
    int           errors;

    function new();
      lead_mask  = {LeadMaskRst, LeadMaskRst};
      sync_mask  = {64'h0, SyncLoRst};
      mode       = MODE_BEAM;
      finger     = 1'b0;
      epoch      = '0;
      unpaired   = '0;
      errors     = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [63:0] val);
      case (idx)
        CFG_LEAD_LO: lead_mask[63:0]   = val;
        CFG_LEAD_HI: lead_mask[127:64] = val;
        CFG_SYNC_LO: sync_mask[63:0]   = val;
        CFG_SYNC_HI: sync_mask[127:64] = val;
        CFG_MODE:    mode              = val[1:0];
        CFG_FINGER:  finger            = val[0];
        default: ;
      endcase
    endfunction

    function void bump_unpaired();
      if (unpaired != 32'hFFFF_FFFF) unpaired++;
    endfunction

    // one accepted word: update state, queue a hit if one is due
    function void note_word(logic [31:0] w, logic [15:0] tdc, logic pmt, logic blk);
      edge_t   cur;
      edge_t   head;
      result_t hit;
      logic [6:0] ch;
      bit trig;
      bit ok;
      bit have;
      bit emit;
      emit = 0;
      hit  = '0;
      if (blk) begin
        epoch = '0;
        edge_queue.delete();
      end
      if (w[31]) begin
        ch          = w[28:22];
        cur.channel = ch;
        cur.epoch   = epoch;
        cur.coarse  = w[10:0];
        cur.fine    = w[21:12];
        if (sync_mask[ch] || tdc == CtsTdc) begin
          // sync channel or cts words carry no hit
        end else if (tdc == RefTdc) begin
          trig = (mode == MODE_BEAM && ch == ChanBeam) ||
                 (mode == MODE_LASER && ch == ChanLaser) ||
                 (mode == MODE_LED && ch == ChanLed);
          if (trig) begin
            hit.hit_kind = HIT_TRIG;
            hit.lead     = cur;
            emit         = 1;
          end else if (finger && ch == ChanFinger) begin
            hit.hit_kind = HIT_FINGER;
            hit.lead     = cur;
            emit         = 1;
          end
        end else if (pmt) begin
          if (lead_mask[ch]) begin
            if (edge_queue.size() < FifoDepth) edge_queue.insert(edge_queue.size(), cur);
          end else if (edge_queue.size() == 0) begin
            bump_unpaired();
          end else begin
            // oldest entry first, one retry, flush on a second miss
            head = edge_queue.pop_front();
            ok   = ({1'b0, head.channel} + 8'd1) == {1'b0, ch};
            have = 1;
            if (!ok) begin
              bump_unpaired();
              if (edge_queue.size() == 0) begin
                bump_unpaired();
                have = 0;
              end else begin
                head = edge_queue.pop_front();
                ok   = ({1'b0, head.channel} + 8'd1) == {1'b0, ch};
              end
            end
            if (have) begin
              if (ok) begin
                hit.hit_kind = HIT_PAIR;
                hit.lead     = head;
                hit.trail    = cur;
                emit         = 1;
              end else begin
                edge_queue.delete();
              end
            end
          end
        end
      end else if (w[31:29] == TagEpoch) begin
        epoch = w[27:0];
      end
      if (emit) begin
        hit.hit_tdc        = tdc;
        hit.unpaired_count = unpaired;
        hits_due.insert(hits_due.size(), hit);
      end
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_hit(result_t got);
      result_t want;
      if (hits_due.size() == 0) begin
        $error("hit with none expected: kind %0d channel %0d", got.hit_kind, got.lead.channel);
        errors++;
        return;
      end
      want = hits_due.pop_front();
      cmp_field("hit_kind", want.hit_kind, got.hit_kind);
      cmp_field("hit_tdc", want.hit_tdc, got.hit_tdc);
      cmp_field("lead_channel", want.lead.channel, got.lead.channel);
      cmp_field("lead_epoch", want.lead.epoch, got.lead.epoch);
      cmp_field("lead_coarse", want.lead.coarse, got.lead.coarse);
      cmp_field("lead_fine", want.lead.fine, got.lead.fine);
      cmp_field("trail_channel", want.trail.channel, got.trail.channel);
      cmp_field("trail_epoch", want.trail.epoch, got.trail.epoch);
      cmp_field("trail_coarse", want.trail.coarse, got.trail.coarse);
      cmp_field("trail_fine", want.trail.fine, got.trail.fine);
      cmp_field("unpaired_count", want.unpaired_count, got.unpaired_count);
    endfunction

    function int pending();
      return hits_due.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  cfg_reg_e            cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  tdc_wup_in_if  in_if ();
  tdc_wup_out_if out_if ();

  tdc_word_unpack_edge_pairing dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  hit_predictor pairing = new();
  logic [6:0]   pair_leads[$];
  bit           calm;
  int           sent;
  int           stall_left;
  int unsigned  cycles;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // timeout
  initial begin
    cycles = 0;
    while (cycles < Limit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAIL tdc_word_unpack_edge_pairing");
    $finish;
  end

  // hit monitor and output back-pressure
  always @(posedge clk_i) begin
    result_t seen;
    if (rst_ni && out_if.valid && out_if.ready) begin
      seen.hit_kind       = hit_kind_e'(out_if.hit_kind);
      seen.hit_tdc        = out_if.hit_tdc;
      seen.lead.channel   = out_if.lead_channel;
      seen.lead.epoch     = out_if.lead_epoch;
      seen.lead.coarse    = out_if.lead_coarse;
      seen.lead.fine      = out_if.lead_fine;
      seen.trail.channel  = out_if.trail_channel;
      seen.trail.epoch    = out_if.trail_epoch;
      seen.trail.coarse   = out_if.trail_coarse;
      seen.trail.fine     = out_if.trail_fine;
      seen.unpaired_count = out_if.unpaired_count;
      pairing.check_hit(seen);
    end
    if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left--;
    end else begin
      out_if.ready <= 1'b1;
      if (!calm && $urandom_range(0, 5) == 0) stall_left = pick_gap();
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] time_word(logic [6:0] ch, logic [9:0] fine,
                                            logic [10:0] coarse, logic [2:0] spare);
    return {1'b1, spare[2:1], ch, fine, spare[0], coarse};
  endfunction

  function automatic logic [31:0] rand_time(logic [6:0] ch);
    return time_word(ch, 10'($urandom), 11'($urandom), 3'($urandom));
  endfunction

  // lead channels whose partner one above is a trailing, non-sync channel
  function automatic void build_pairs();
    pair_leads.delete();
    for (int c = 0; c < 127; c++) begin
      if (pairing.lead_mask[c] && !pairing.lead_mask[c+1] &&
          !pairing.sync_mask[c] && !pairing.sync_mask[c+1])
        pair_leads.insert(pair_leads.size(), 7'(c));
    end
  endfunction

  // present one item and hold it until accepted
  task automatic send_word(input logic [31:0] w, input logic [15:0] tdc,
                           input logic pmt, input logic blk);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.word        <= w;
    in_if.tdc_id      <= tdc;
    in_if.pmt_board   <= pmt;
    in_if.block_start <= blk;
    do @(posedge clk_i); while (!in_if.ready);
    pairing.note_word(w, tdc, pmt, blk);
    sent++;
  endtask

  // stop input, wait for every expected hit, then let the pipeline empty
  task automatic settle();
    in_if.valid <= 1'b0;
    while (pairing.pending() > 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // write all six registers back to back, upper bits of narrow ones random
  task automatic load_cfg(input logic [63:0] lead_lo, input logic [63:0] lead_hi,
                          input logic [63:0] sync_lo, input logic [63:0] sync_hi,
                          input logic [1:0] mode, input logic fing);
    logic [63:0] vals [6];
    cfg_reg_e    idx;
    vals[0] = lead_lo;
    vals[1] = lead_hi;
    vals[2] = sync_lo;
    vals[3] = sync_hi;
    vals[4] = {$urandom, $urandom};
    vals[4][1:0] = mode;
    vals[5] = {$urandom, $urandom};
    vals[5][0] = fing;
    idx = idx.first();
    for (int i = 0; i < 6; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= idx;
      cfg_data <= vals[i];
      pairing.set_reg(idx, vals[i]);
      @(posedge clk_i);
      idx = idx.next();
    end
    cfg_we <= 1'b0;
    build_pairs();
  endtask

  // leading edges on one pmt board, then their trailing partners
  task automatic pmt_burst();
    logic [15:0] tdc;
    logic [6:0]  leads[$];
    logic [6:0]  ch;
    int n;
    do tdc = 16'($urandom); while (tdc == RefTdc || tdc == CtsTdc);
    if ($urandom_range(0, 3) == 0)
      send_word({TagEpoch, 29'($urandom)}, tdc, 1'b1, 1'b1);
    n = ($urandom_range(0, 11) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 4);
    if (pair_leads.size() == 0) begin
      repeat (n) send_word(rand_time(7'($urandom)), tdc, 1'b1, 1'b0);
      return;
    end
    repeat (n) begin
      ch = pair_leads[$urandom_range(0, pair_leads.size() - 1)];
      leads.insert(leads.size(), ch);
      send_word(rand_time(ch), tdc, 1'b1, 1'b0);
      if ($urandom_range(0, 5) == 0)
        send_word({TagEpoch, 29'($urandom)}, tdc, 1'b1, 1'b0);
    end
    foreach (leads[i]) begin
      ch = ($urandom_range(0, 99) < 85) ? leads[i] + 7'd1 : 7'($urandom);
      send_word(rand_time(ch), tdc, 1'b1, 1'b0);
    end
  endtask

  task automatic random_traffic(input int n);
    int first;
    int pick;
    logic [6:0] ch;
    first = sent;
    while (sent - first < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        pmt_burst();
      end else if (pick < 65) begin
        // reference tdc, mostly on the trigger and finger channels
        case ($urandom_range(0, 4))
          0: ch = ChanFinger;
          1: ch = ChanBeam;
          2: ch = ChanLaser;
          3: ch = ChanLed;
          default: ch = 7'($urandom);
        endcase
        send_word(rand_time(ch), RefTdc, 1'($urandom), 1'b0);
      end else if (pick < 70) begin
        send_word(rand_time(7'($urandom)), CtsTdc, 1'($urandom), 1'b0);
      end else if (pick < 80) begin
        // header, debug and other non-time words
        send_word({1'b0, 2'($urandom_range(0, 2)), 29'($urandom)}, 16'($urandom),
                  1'($urandom), 1'($urandom_range(0, 7) == 0));
      end else begin
        send_word($urandom, ($urandom_range(0, 9) == 0) ? RefTdc : 16'($urandom),
                  1'($urandom), 1'($urandom_range(0, 7) == 0));
      end
    end
  endtask

  // stimulus
  initial begin
    in_if.valid       = 1'b0;
    in_if.word        = '0;
    in_if.tdc_id      = '0;
    in_if.pmt_board   = 1'b0;
    in_if.block_start = 1'b0;
    out_if.ready      = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = CFG_LEAD_LO;
    cfg_data          = '0;
    calm              = 1'b0;
    sent              = 0;
    stall_left        = 0;
    rst_ni            = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed items under reset defaults: odd channels lead, channel 0 is sync
    send_word(32'h6FFF_FFFF, 16'hFFFF, 1'b1, 1'b1);
    send_word(time_word(7'd3, 10'h3FF, 11'h7FF, 3'b111), 16'hFFFF, 1'b1, 1'b0);
    send_word(time_word(7'd4, 10'h000, 11'h000, 3'b000), 16'hFFFF, 1'b1, 1'b0);
    // trailing edge with nothing queued
    send_word(time_word(7'd2, 10'h155, 11'h2AA, 3'b010), 16'hFFFF, 1'b1, 1'b0);
    send_word(time_word(7'd0, 10'h3FF, 11'h7FF, 3'b000), 16'hFFFF, 1'b1, 1'b0);
    send_word(time_word(ChanBeam, 10'h011, 11'h022, 3'b000), CtsTdc, 1'b1, 1'b0);
    send_word(time_word(ChanBeam, 10'h3FF, 11'h7FF, 3'b101), RefTdc, 1'b0, 1'b0);
    send_word(time_word(ChanFinger, 10'h001, 11'h001, 3'b000), RefTdc, 1'b0, 1'b0);
    send_word(time_word(ChanLed, 10'h002, 11'h002, 3'b000), RefTdc, 1'b1, 1'b0);
    // first miss, retry pairs with the next entry
    send_word(time_word(7'd9, 10'h010, 11'h100, 3'b000), 16'h0000, 1'b1, 1'b0);
    send_word(time_word(7'd11, 10'h020, 11'h200, 3'b000), 16'h0000, 1'b1, 1'b0);
    send_word(time_word(7'd12, 10'h030, 11'h300, 3'b000), 16'h0000, 1'b1, 1'b0);
    // first miss leaves the queue empty
    send_word(time_word(7'd13, 10'h040, 11'h400, 3'b000), 16'h0000, 1'b1, 1'b0);
    send_word(time_word(7'd20, 10'h050, 11'h500, 3'b000), 16'h0000, 1'b1, 1'b0);
    // second miss flushes the queue
    send_word(time_word(7'd21, 10'h060, 11'h600, 3'b000), 16'h0000, 1'b1, 1'b0);
    send_word(time_word(7'd23, 10'h070, 11'h700, 3'b000), 16'h0000, 1'b1, 1'b0);
    send_word(time_word(7'd30, 10'h080, 11'h080, 3'b000), 16'h0000, 1'b1, 1'b0);
    // top channel has no partner above it
    send_word(time_word(7'd127, 10'h3FF, 11'h7FF, 3'b111), 16'h0000, 1'b1, 1'b0);
    send_word(time_word(7'd126, 10'h3FF, 11'h7FF, 3'b111), 16'h0000, 1'b1, 1'b0);
    send_word(32'h0000_0000, 16'h0000, 1'b0, 1'b0);
    send_word(32'h6000_0000, 16'h0000, 1'b1, 1'b0);
    send_word(32'h5FFF_FFFF, 16'h0000, 1'b1, 1'b0);
    // block start drops the queued edge before the trailing edge
    send_word(time_word(7'd1, 10'h090, 11'h090, 3'b000), 16'h0042, 1'b1, 1'b0);
    send_word(time_word(7'd2, 10'h0A0, 11'h0A0, 3'b000), 16'h0042, 1'b1, 1'b1);
    send_word(time_word(7'd3, 10'h0B0, 11'h0B0, 3'b000), 16'h1234, 1'b0, 1'b0);
    settle();

    // random phases over a range of register settings
    load_cfg(LeadMaskRst, LeadMaskRst, SyncLoRst, 64'h0, MODE_BEAM, 1'b1);
    random_traffic(140);
    settle();

    calm = 1'b1;
    load_cfg(LeadMaskRst, LeadMaskRst, 64'h1 << $urandom_range(0, 63),
             64'h1 << $urandom_range(0, 63), MODE_LASER, 1'b0);
    random_traffic(140);
    settle();
    calm = 1'b0;

    load_cfg(64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555, 64'h0, 64'h0, MODE_LED, 1'b1);
    random_traffic(140);
    settle();

    load_cfg(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'h0, 2'd3, 1'b1);
    random_traffic(140);
    settle();

    load_cfg(64'h0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, MODE_BEAM, 1'b0);
    random_traffic(140);
    settle();

    load_cfg({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom} & {$urandom, $urandom},
             {$urandom, $urandom} & {$urandom, $urandom}, 2'($urandom), 1'($urandom));
    random_traffic(140);
    settle();

    load_cfg(LeadMaskRst, LeadMaskRst, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 2'($urandom_range(0, 2)),
             1'($urandom));
    random_traffic(140);
    settle();

    if (pairing.errors == 0 && pairing.pending() == 0) begin
      $display("PASS tdc_word_unpack_edge_pairing");
    end else begin
      $display("FAIL tdc_word_unpack_edge_pairing");
    end
    $finish;
  end

endmodule
